[src/sidt_pkg.sv]
// ----------------------------------------------------------------------------
// sidt_pkg: shared types and constants for the session depth tracker
// Holds the item codes, Telnet byte codes, parser phases and the state and
// result records passed between the tracker modules.
// ----------------------------------------------------------------------------
package sidt_pkg;

    typedef enum logic [1:0] {
        OP_TELNET   = 2'd0,
        OP_CONNECT  = 2'd1,
        OP_MQTT_OP  = 2'd2,
        OP_FINALIZE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_DATA   = 3'd0,
        PH_CMD    = 3'd1,
        PH_OPT    = 3'd2,
        PH_SUB    = 3'd3,
        PH_SUBCMD = 3'd4
    } phase_t;

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;

    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_VT  = 8'd11;
    localparam logic [7:0] CH_FF  = 8'd12;

    localparam logic [1:0] LVL_CONTENT = 2'd1;
    localparam logic [1:0] LVL_LINE    = 2'd2;
    localparam logic [1:0] LVL_MAX     = 2'd3;
    localparam logic [1:0] OP_COUNT_MAX = 2'd2;

    typedef struct packed {
        logic [1:0] depth;
        phase_t     phase;
        logic       line_has_content;
        logic       previous_was_cr;
        logic       mqtt_connected;
        logic [1:0] mqtt_op_count;
        logic       frozen;
    } sidt_state_t;

    typedef struct packed {
        logic       finalize_accepted;
        logic       is_finalized;
        logic [1:0] depth_level;
    } sidt_result_t;

endpackage

[src/sidt_core.sv]
// ----------------------------------------------------------------------------
// sidt_core: session state and per-item update
// Holds the session state registers and computes the state change and the
// result for one item combinationally.
// ----------------------------------------------------------------------------
module sidt_core
    import sidt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  op_t          operation,
    input  logic [7:0]   data_byte,
    output sidt_result_t result,
    output sidt_state_t  status
);

    sidt_state_t state_reg;
    sidt_state_t state_next;
    logic [1:0]  lift_lvl;
    logic [1:0]  count_new;
    logic        accepted;

    always_comb
    begin
        state_next = state_reg;
        lift_lvl   = 2'd0;
        count_new  = state_reg.mqtt_op_count;
        accepted   = 1'b0;

        if (operation == OP_FINALIZE)
        begin
            if (!state_reg.frozen)
            begin
                state_next.frozen = 1'b1;
                accepted          = 1'b1;
            end
        end
        else if (!state_reg.frozen)
        begin
            case (operation)
                OP_TELNET:
                begin
                    case (state_reg.phase)
                        PH_CMD:
                        begin
                            if (data_byte inside {B_WILL, B_WONT, B_DO, B_DONT})
                                state_next.phase = PH_OPT;
                            else if (data_byte == B_SB)
                                state_next.phase = PH_SUB;
                            else
                                state_next.phase = PH_DATA;
                        end
                        PH_OPT:
                            state_next.phase = PH_DATA;
                        PH_SUB:
                        begin
                            if (data_byte == B_IAC)
                                state_next.phase = PH_SUBCMD;
                        end
                        PH_SUBCMD:
                            state_next.phase = (data_byte == B_SE) ? PH_DATA : PH_SUB;
                        default:
                        begin
                            // Unused phase codes fall back to plain data.
                            if (data_byte == B_IAC)
                            begin
                                state_next.previous_was_cr = 1'b0;
                                state_next.phase           = PH_CMD;
                            end
                            else
                            begin
                                state_next.phase = PH_DATA;
                                if (data_byte == CH_CR)
                                begin
                                    if (state_reg.line_has_content)
                                        lift_lvl = (state_reg.depth < LVL_LINE) ?
                                                   LVL_LINE : LVL_MAX;
                                    state_next.line_has_content = 1'b0;
                                    state_next.previous_was_cr  = 1'b1;
                                end
                                else if (data_byte == CH_LF)
                                begin
                                    // An LF right after CR closes the same line end.
                                    if (!state_reg.previous_was_cr &&
                                        state_reg.line_has_content)
                                        lift_lvl = (state_reg.depth < LVL_LINE) ?
                                                   LVL_LINE : LVL_MAX;
                                    state_next.line_has_content = 1'b0;
                                    state_next.previous_was_cr  = 1'b0;
                                end
                                else
                                begin
                                    state_next.previous_was_cr = 1'b0;
                                    if (!(data_byte inside {CH_SP, CH_TAB, CH_VT, CH_FF}))
                                    begin
                                        lift_lvl = (state_reg.depth >= LVL_LINE) ?
                                                   LVL_MAX : LVL_CONTENT;
                                        state_next.line_has_content = 1'b1;
                                    end
                                end
                            end
                        end
                    endcase
                end
                OP_CONNECT:
                begin
                    state_next.mqtt_connected = 1'b1;
                    lift_lvl                  = LVL_CONTENT;
                end
                OP_MQTT_OP:
                begin
                    if (state_reg.mqtt_connected)
                    begin
                        if (state_reg.mqtt_op_count < OP_COUNT_MAX)
                            count_new = state_reg.mqtt_op_count + 2'd1;
                        state_next.mqtt_op_count = count_new;
                        lift_lvl = (count_new == 2'd1) ? LVL_LINE : LVL_MAX;
                    end
                end
                default:
                    lift_lvl = 2'd0;
            endcase
        end

        if (lift_lvl > state_reg.depth)
            state_next.depth = lift_lvl;

        result.depth_level       = state_next.depth;
        result.is_finalized      = state_next.frozen;
        result.finalize_accepted = accepted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{depth: 2'd0, phase: PH_DATA, line_has_content: 1'b0,
                           previous_was_cr: 1'b0, mqtt_connected: 1'b0,
                           mqtt_op_count: 2'd0, frozen: 1'b0};
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    assign status = state_reg;

endmodule

[src/session_interaction_depth_tracker.sv]
// ----------------------------------------------------------------------------
// session_interaction_depth_tracker: top level of the session depth tracker
// Input register, session update and result register for one session.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle while the output is not stalled and
// returns one result beat for each input beat: an accepted beat is held in
// the input register, then the session state and the result register are
// written together by one combinational update. The depth level never falls;
// after a finalize beat every later beat leaves the state alone. Reset clears
// the session; there is no other way to start a new one.
module session_interaction_depth_tracker
    import sidt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] operation
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [1:0] depth_level, [2] is_finalized,
                                       // [3] finalize_accepted, [7:4] zero
);

    logic         in_valid_reg;
    op_t          op_reg;
    logic [7:0]   byte_reg;
    logic         out_valid_reg;
    sidt_result_t out_reg;
    sidt_result_t result;
    sidt_state_t  status;
    logic         advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg   <= op_t'(s_axis_tuser);
            byte_reg <= s_axis_tdata;
        end
    end

    sidt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .operation (op_reg),
        .data_byte (byte_reg),
        .result    (result),
        .status    (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg};

    a_depth_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        status.depth >= $past(status.depth))
        else $error("session depth decreased");

    a_frozen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(status.frozen) |-> status.frozen && $stable(status.depth))
        else $error("frozen session changed");

    a_accept_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.finalize_accepted |=> status.frozen && !$past(status.frozen))
        else $error("finalize accepted without freezing a live session");

endmodule

[tb/sv/session_depth_checker.sv]
// ----------------------------------------------------------------------------
// session_depth_checker: result checker for the session depth tracker
// Watches both stream channels, keeps its own copy of the session state,
// works out the result of every accepted input beat and compares it field by
// field with the result beats in order of arrival.
// ----------------------------------------------------------------------------
module session_depth_checker
    import sidt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] operation
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [1:0] depth_level, [2] is_finalized,
                                       // [3] finalize_accepted, [7:4] zero
    output int         mismatches,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Session state as the tracker should hold it.
    logic [1:0]   level;
    phase_t       parse_at;
    logic         has_text;
    logic         after_cr;
    logic         connected;
    logic [1:0]   op_count;
    logic         sealed;

    sidt_result_t due_results[$];

    function automatic void raise_to(logic [1:0] lvl);
        if (lvl > level)
            level = lvl;
    endfunction

    function automatic void take_text(logic [7:0] b);
        if (b == CH_CR) begin
            if (has_text)
                raise_to(level < LVL_LINE ? LVL_LINE : LVL_MAX);
            has_text = 1'b0;
            after_cr = 1'b1;
        end else if (b == CH_LF) begin
            if (!after_cr && has_text)
                raise_to(level < LVL_LINE ? LVL_LINE : LVL_MAX);
            has_text = 1'b0;
            after_cr = 1'b0;
        end else begin
            after_cr = 1'b0;
            if (!(b inside {CH_SP, CH_TAB, CH_VT, CH_FF})) begin
                raise_to(level >= LVL_LINE ? LVL_MAX : LVL_CONTENT);
                has_text = 1'b1;
            end
        end
    endfunction

    function automatic void parse_telnet(logic [7:0] b);
        case (parse_at)
            PH_CMD:
                if (b inside {B_WILL, B_WONT, B_DO, B_DONT})
                    parse_at = PH_OPT;
                else if (b == B_SB)
                    parse_at = PH_SUB;
                else
                    parse_at = PH_DATA;
            PH_OPT:
                parse_at = PH_DATA;
            PH_SUB:
                if (b == B_IAC)
                    parse_at = PH_SUBCMD;
            PH_SUBCMD:
                parse_at = (b == B_SE) ? PH_DATA : PH_SUB;
            default:
                if (b == B_IAC) begin
                    after_cr = 1'b0;
                    parse_at = PH_CMD;
                end else begin
                    parse_at = PH_DATA;
                    take_text(b);
                end
        endcase
    endfunction

    function automatic sidt_result_t session_update(op_t op, logic [7:0] b);
        sidt_result_t r;
        r.finalize_accepted = 1'b0;
        if (op == OP_FINALIZE) begin
            if (!sealed) begin
                sealed = 1'b1;
                r.finalize_accepted = 1'b1;
            end
        end else if (!sealed) begin
            case (op)
                OP_TELNET:
                    parse_telnet(b);
                OP_CONNECT:
                begin
                    connected = 1'b1;
                    raise_to(LVL_CONTENT);
                end
                default:
                    if (connected) begin
                        if (op_count < OP_COUNT_MAX)
                            op_count = op_count + 2'd1;
                        raise_to(op_count == 2'd1 ? LVL_LINE : LVL_MAX);
                    end
            endcase
        end
        r.depth_level = level;
        r.is_finalized = sealed;
        return r;
    endfunction

    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sidt_result_t want;
        sidt_result_t got;
        if (!rst_n) begin
            level = 2'd0;
            parse_at = PH_DATA;
            has_text = 1'b0;
            after_cr = 1'b0;
            connected = 1'b0;
            op_count = 2'd0;
            sealed = 1'b0;
            due_results.delete();
            mismatches = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[3:0];
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result beat %h arrived with no input beat pending",
                                 $realtime, m_axis_tdata);
                end else begin
                    want = due_results.pop_front();
                    if (got.depth_level !== want.depth_level)
                        note_mismatch("depth_level", want.depth_level, got.depth_level);
                    if (got.is_finalized !== want.is_finalized)
                        note_mismatch("is_finalized", want.is_finalized, got.is_finalized);
                    if (got.finalize_accepted !== want.finalize_accepted)
                        note_mismatch("finalize_accepted", want.finalize_accepted,
                                      got.finalize_accepted);
                    if (m_axis_tdata[7:4] !== 4'd0)
                        note_mismatch("tdata pad bits", 0, m_axis_tdata[7:4]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(session_update(op_t'(s_axis_tuser), s_axis_tdata));
        end
        outstanding = due_results.size();
    end

endmodule

[tb/sv/tb_session_interaction_depth_tracker.sv]
// ----------------------------------------------------------------------------
// tb_session_interaction_depth_tracker: testbench top for the depth tracker
// Drives Telnet byte streams and MQTT events in stages that hold the depth
// level low for long stretches, so that parser faults stay visible, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_session_interaction_depth_tracker;
    timeunit 1ns;
    timeprecision 1ps;
    import sidt_pkg::*;

    typedef struct {
        op_t        op;
        logic [7:0] b;
    } beat_t;

    typedef enum int {
        K_NEG, K_SUB, K_CMD, K_WS, K_CR, K_LF, K_TEXT, K_CONN, K_OP, K_NOISE
    } chunk_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;   // [7:0] data_byte
    logic [1:0] s_axis_tuser = 2'd0;   // [1:0] operation
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [1:0] depth_level, [2] is_finalized,
                                       // [3] finalize_accepted, [7:4] zero
    int         mismatches;
    int         outstanding;
    logic       calm = 1'b0;
    beat_t      plan[$];

    session_interaction_depth_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    session_depth_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 34);
    end

    function automatic void add(op_t op, logic [7:0] b);
        beat_t x;
        x.op = op;
        x.b = b;
        plan.push_back(x);
    endfunction

    function automatic void add_byte(logic [7:0] b);
        add(OP_TELNET, b);
    endfunction

    // Any byte that counts as line content on its own.
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(254));
        while (c inside {CH_CR, CH_LF, CH_SP, CH_TAB, CH_VT, CH_FF});
        return c;
    endfunction

    function automatic void add_chunk(chunk_t k);
        logic [7:0] c;
        int unsigned n;
        case (k)
            K_NEG:
            begin
                add_byte(B_IAC);
                add_byte(8'(B_WILL + $urandom_range(3)));
                add_byte(8'($urandom_range(255)));
            end
            K_SUB:
            begin
                add_byte(B_IAC);
                add_byte(B_SB);
                n = $urandom_range(6);
                repeat (n) begin
                    // An IAC inside the payload must not be followed by SE here.
                    if ($urandom_range(7) == 0) begin
                        add_byte(B_IAC);
                        do
                            c = 8'($urandom_range(255));
                        while (c == B_SE);
                        add_byte(c);
                    end else begin
                        add_byte(8'($urandom_range(254)));
                    end
                end
                add_byte(B_IAC);
                add_byte(B_SE);
            end
            K_CMD:
            begin
                add_byte(B_IAC);
                if ($urandom_range(3) == 0)
                    c = B_IAC;
                else
                    do
                        c = 8'($urandom_range(255));
                    while (c >= B_SB && c <= B_DONT);
                add_byte(c);
            end
            K_WS:
            begin
                case ($urandom_range(3))
                    0: add_byte(CH_SP);
                    1: add_byte(CH_TAB);
                    2: add_byte(CH_VT);
                    default: add_byte(CH_FF);
                endcase
            end
            K_CR:
            begin
                add_byte(CH_CR);
                if ($urandom_range(1) == 1)
                    add_byte(CH_LF);
            end
            K_LF:
                add_byte(CH_LF);
            K_TEXT:
            begin
                n = $urandom_range(4, 1);
                repeat (n) add_byte(text_char());
            end
            K_CONN:
                add(OP_CONNECT, 8'($urandom_range(255)));
            K_OP:
                add(OP_MQTT_OP, 8'($urandom_range(255)));
            default:
                add(op_t'($urandom_range(2)), 8'($urandom_range(255)));
        endcase
    endfunction

    function automatic void fill_stage(int unsigned count, logic [15:0] kinds);
        int unsigned base;
        chunk_t k;
        base = plan.size();
        while (plan.size() - base < count) begin
            do
                k = chunk_t'($urandom_range(K_NOISE));
            while (!kinds[k]);
            add_chunk(k);
        end
    endfunction

    task automatic send_beat(beat_t x);
        while (!calm && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= x.b;
        s_axis_tuser <= x.op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drive_plan();
        foreach (plan[i])
            send_beat(plan[i]);
        s_axis_tvalid <= 1'b0;
        plan.delete();
    endtask

    // Hold the sender until the checker has seen every result beat.
    task automatic drain();
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    localparam logic [15:0] KS_QUIET = (16'd1 << K_NEG) | (16'd1 << K_SUB) | (16'd1 << K_CMD)
                                     | (16'd1 << K_WS);

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Parser corners with no effect on the level: an operation before any
        // connect, option bytes at both extremes, a subnegotiation carrying
        // text, a line end and an escaped IAC, an escaped IAC in the data
        // phase, and whitespace and line ends on an empty line.
        add(OP_MQTT_OP, 8'hFF);
        add_byte(B_IAC); add_byte(B_WILL); add_byte(8'h00);
        add_byte(B_IAC); add_byte(B_DONT); add_byte(8'hFF);
        add_byte(B_IAC); add_byte(B_SB); add_byte(8'h41); add_byte(CH_CR);
        add_byte(B_IAC); add_byte(B_IAC); add_byte(B_IAC); add_byte(B_SE);
        add_byte(B_IAC); add_byte(B_IAC);
        add_byte(CH_CR); add_byte(CH_LF);
        add_byte(CH_SP); add_byte(CH_TAB); add_byte(CH_VT); add_byte(CH_FF);
        drive_plan();
        drain();

        // Level stays at zero: only commands, whitespace, empty lines and
        // operations without a connect.
        fill_stage(450, KS_QUIET | (16'd1 << K_CR) | (16'd1 << K_LF) | (16'd1 << K_OP));
        drive_plan();
        drain();

        // Level one: content and connects, but no line ends as data.
        add(OP_CONNECT, 8'h00);
        add_byte(8'h00);
        fill_stage(450, KS_QUIET | (16'd1 << K_TEXT) | (16'd1 << K_CONN));
        add_byte(8'hFE);
        drive_plan();
        drain();

        // Level two without any idling: content survives a negotiation before
        // the line end, then nothing pushes the level further, not even a
        // single MQTT operation.
        calm <= 1'b1;
        add_chunk(K_NEG);
        add_byte(CH_CR);
        fill_stage(150, KS_QUIET | (16'd1 << K_CR) | (16'd1 << K_LF) | (16'd1 << K_CONN));
        add_chunk(K_OP);
        fill_stage(150, KS_QUIET | (16'd1 << K_CR) | (16'd1 << K_LF) | (16'd1 << K_CONN));
        drive_plan();
        drain();
        calm <= 1'b0;

        // Everything, broken sequences among them.
        fill_stage(550, 16'hFFFF);
        drive_plan();
        drain();

        // Freeze the session; later beats, repeated finalizes among them,
        // must change nothing.
        add(OP_FINALIZE, 8'($urandom_range(255)));
        repeat (30) begin
            if ($urandom_range(4) == 0)
                add(OP_FINALIZE, 8'($urandom_range(255)));
            else
                add_chunk($urandom_range(1) ? K_NOISE : K_TEXT);
        end
        drive_plan();
        drain();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
